// File: hdl/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// Shared types and constants of the software timer bank: command and result
// codes, sequencer states and the next-due cap.
// ----------------------------------------------------------------------------
package stb_pkg;

   // command codes on req_mode
   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_START = 2'd1,
      MODE_STOP  = 2'd2,
      MODE_QUERY = 2'd3
   } mode_type;

   // result codes on rsp_kind
   typedef enum logic [1:0] {
      KIND_DONE      = 2'd0,
      KIND_EXPIRED   = 2'd1,
      KIND_NO_EXPIRY = 2'd2,
      KIND_NEXT_DUE  = 2'd3
   } kind_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_EMIT = 2'd2
   } state_type;

   localparam int KIND_BITS    = 2;
   localparam int INDEX_BITS   = 4;
   localparam int DUR_BITS     = 24;
   localparam int DUE_BITS     = 20;
   localparam logic [DUE_BITS-1:0] NEXT_DUE_CAP = 20'd999999;

endpackage

// File: hdl/stb_ram.sv
// ----------------------------------------------------------------------------
// stb_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module stb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/software_timer_bank.sv
// ----------------------------------------------------------------------------
// software_timer_bank
// Bank of countdown timers with start, stop, tick and next-due query.
// ----------------------------------------------------------------------------
// One command word is taken at a time. Start and stop apply their update on
// acceptance and give their result word from the emit state. Tick and query
// sweep the count memory one timer per cycle through its single read port,
// a tick pausing while an expiry word cannot enter the result register. Any
// command is held up while a finished word cannot enter the result register
// because the word ahead of it is stalled. A tick yields one expiry word per
// expired timer in ascending index order, the final one marked last, or one
// no-expiry word. Counts live in a RAM; running flags are flip-flops cleared
// by reset, so no clearing pass is needed after reset.
module software_timer_bank #(
   parameter int TIMERS     = 16,
   parameter int COUNT_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_mode,
   input  logic [stb_pkg::INDEX_BITS-1:0] req_timer_index,
   input  logic [stb_pkg::DUR_BITS-1:0]  req_duration,
   input  logic [stb_pkg::DUR_BITS-1:0]  req_elapsed,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_kind,
   output logic [stb_pkg::INDEX_BITS-1:0] rsp_expired_index,
   output logic [stb_pkg::DUE_BITS-1:0]  rsp_next_due,
   output logic                          rsp_last
);

   localparam int IDX_BITS = (TIMERS > 1) ? $clog2(TIMERS) : 1;
   localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_BITS) - 33'd1;

   // sequencer registers
   stb_pkg::state_type            state_ff, state_in;
   stb_pkg::mode_type             mode_ff, mode_in;
   logic [IDX_BITS-1:0]           ptr_ff, ptr_in;
   logic [stb_pkg::DUR_BITS-1:0]  elapsed_ff, elapsed_in;
   logic [stb_pkg::DUE_BITS-1:0]  least_ff, least_in;
   logic                          pend_valid_ff, pend_valid_in;
   logic [stb_pkg::INDEX_BITS-1:0] pend_idx_ff, pend_idx_in;
   logic [TIMERS-1:0]             run_ff, run_in;

   // output register
   logic                          out_valid_ff, out_valid_in;
   stb_pkg::kind_type             out_kind_ff, out_kind_in;
   logic [stb_pkg::INDEX_BITS-1:0] out_idx_ff, out_idx_in;
   logic [stb_pkg::DUE_BITS-1:0]  out_due_ff, out_due_in;
   logic                          out_last_ff, out_last_in;

   // memory port signals
   logic                          wr_en;
   logic [IDX_BITS-1:0]           wr_addr;
   logic [COUNT_BITS-1:0]         wr_data;
   logic                          rd_en;
   logic [IDX_BITS-1:0]           rd_addr;
   logic [COUNT_BITS-1:0]         rd_data;

   // decode helpers
   logic                          accept;
   logic                          slot_free;
   logic                          in_range;
   logic [IDX_BITS-1:0]           req_addr;
   logic [COUNT_BITS-1:0]         dur_sat;
   logic                          cur_run;
   logic                          expired;
   logic                          advance;

   stb_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (TIMERS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != stb_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !out_valid_ff || !rsp_stall;
   assign in_range  = (32'(req_timer_index) < 32'(TIMERS));
   assign req_addr  = IDX_BITS'(req_timer_index);
   assign dur_sat   = (33'(req_duration) > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0]
                                                      : COUNT_BITS'(req_duration);
   assign cur_run   = run_ff[ptr_ff];
   assign expired   = (32'(rd_data) <= 32'(elapsed_ff));

   // next state, memory access and result words
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      ptr_in        = ptr_ff;
      elapsed_in    = elapsed_ff;
      least_in      = least_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      run_in        = run_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_kind_in   = out_kind_ff;
      out_idx_in    = out_idx_ff;
      out_due_in    = out_due_ff;
      out_last_in   = out_last_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      advance       = 1'b1;

      case (state_ff)
         stb_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in    = stb_pkg::mode_type'(req_mode);
               elapsed_in = req_elapsed;
               case (stb_pkg::mode_type'(req_mode))
                  stb_pkg::MODE_START: begin
                     if (in_range && (req_duration != '0)) begin
                        wr_en            = 1'b1;
                        wr_addr          = req_addr;
                        wr_data          = dur_sat;
                        run_in[req_addr] = 1'b1;
                     end
                     state_in = stb_pkg::ST_EMIT;
                  end
                  stb_pkg::MODE_STOP: begin
                     if (in_range) begin
                        run_in[req_addr] = 1'b0;
                     end
                     state_in = stb_pkg::ST_EMIT;
                  end
                  default: begin
                     // tick or query: fetch timer 0 and start the sweep
                     rd_en         = 1'b1;
                     rd_addr       = '0;
                     ptr_in        = '0;
                     least_in      = stb_pkg::NEXT_DUE_CAP;
                     pend_valid_in = 1'b0;
                     state_in      = stb_pkg::ST_SCAN;
                  end
               endcase
            end
         end

         stb_pkg::ST_SCAN: begin
            if (mode_ff == stb_pkg::MODE_TICK) begin
               if (cur_run) begin
                  if (expired) begin
                     // hold the newest expiry back so the final one can carry last
                     if (pend_valid_ff && !slot_free) begin
                        advance = 1'b0;
                     end else begin
                        if (pend_valid_ff) begin
                           out_valid_in = 1'b1;
                           out_kind_in  = stb_pkg::KIND_EXPIRED;
                           out_idx_in   = pend_idx_ff;
                           out_due_in   = '0;
                           out_last_in  = 1'b0;
                        end
                        pend_valid_in  = 1'b1;
                        pend_idx_in    = stb_pkg::INDEX_BITS'(ptr_ff);
                        wr_en          = 1'b1;
                        wr_data        = '0;
                        run_in[ptr_ff] = 1'b0;
                     end
                  end else begin
                     wr_en   = 1'b1;
                     wr_data = COUNT_BITS'(32'(rd_data) - 32'(elapsed_ff));
                  end
               end
            end else begin
               // query: running minimum against the cap
               if (cur_run && (32'(rd_data) < 32'(least_ff))) begin
                  least_in = stb_pkg::DUE_BITS'(rd_data);
               end
            end

            if (advance) begin
               if (ptr_ff == IDX_BITS'(TIMERS - 1)) begin
                  state_in = stb_pkg::ST_EMIT;
               end else begin
                  ptr_in  = IDX_BITS'(ptr_ff + 1'b1);
                  rd_en   = 1'b1;
                  rd_addr = IDX_BITS'(ptr_ff + 1'b1);
               end
            end
         end

         stb_pkg::ST_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_idx_in   = '0;
               out_due_in   = '0;
               out_last_in  = 1'b1;
               case (mode_ff)
                  stb_pkg::MODE_TICK: begin
                     if (pend_valid_ff) begin
                        out_kind_in = stb_pkg::KIND_EXPIRED;
                        out_idx_in  = pend_idx_ff;
                     end else begin
                        out_kind_in = stb_pkg::KIND_NO_EXPIRY;
                     end
                  end
                  stb_pkg::MODE_QUERY: begin
                     out_kind_in = stb_pkg::KIND_NEXT_DUE;
                     out_due_in  = least_ff;
                  end
                  default: begin
                     out_kind_in = stb_pkg::KIND_DONE;
                  end
               endcase
               pend_valid_in = 1'b0;
               state_in      = stb_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = stb_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= stb_pkg::ST_IDLE;
         pend_valid_ff <= 1'b0;
         run_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         run_ff        <= run_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      ptr_ff      <= ptr_in;
      elapsed_ff  <= elapsed_in;
      least_ff    <= least_in;
      pend_idx_ff <= pend_idx_in;
      out_kind_ff <= out_kind_in;
      out_idx_ff  <= out_idx_in;
      out_due_ff  <= out_due_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_kind_ff;
   assign rsp_expired_index = out_idx_ff;
   assign rsp_next_due      = out_due_ff;
   assign rsp_last          = out_last_ff;

endmodule

// File: hdl/stb_checker.sv
// ----------------------------------------------------------------------------
// stb_checker
// Port-level checks on the result channel of the software timer bank.
// ----------------------------------------------------------------------------
module stb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [1:0]                     rsp_kind,
   input logic [stb_pkg::INDEX_BITS-1:0] rsp_expired_index,
   input logic [stb_pkg::DUE_BITS-1:0]   rsp_next_due,
   input logic                           rsp_last
);

   // a stalled word stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_last)
         && $stable(rsp_expired_index) && $stable(rsp_next_due))
      else $error("stalled result word changed");

   // only expiry words can be non-final
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != stb_pkg::KIND_EXPIRED) |-> rsp_last)
      else $error("single result word without last");

   // next-due value stays within its range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == stb_pkg::KIND_NEXT_DUE) |->
         (rsp_next_due != '0) && (rsp_next_due <= stb_pkg::NEXT_DUE_CAP))
      else $error("next due out of range");

   // unused fields read as zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         ((rsp_kind == stb_pkg::KIND_NEXT_DUE) || (rsp_next_due == '0)) &&
         ((rsp_kind == stb_pkg::KIND_EXPIRED) || (rsp_expired_index == '0)))
      else $error("unused result field not zero");

endmodule

bind software_timer_bank stb_checker u_stb_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_kind          (rsp_kind),
   .rsp_expired_index (rsp_expired_index),
   .rsp_next_due      (rsp_next_due),
   .rsp_last          (rsp_last)
);
